// ===== src/bbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbrs_pkg
// Shared types and constants of the bitmap block request server.
// ----------------------------------------------------------------------------
package bbrs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SRC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // input tdata layout
    localparam int IN_DATA_W = 56;
    localparam int PIX_LSB   = 0;
    localparam int VAL_LSB   = 16;
    localparam int SRC_LSB   = 24;
    localparam int LEN_LSB   = 32;
    localparam int REQ_LSB   = 40;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    localparam logic KIND_SETUP = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic [7:0] WHITE_VALUE = 8'hff;
    localparam logic [7:0] REQ_LEN     = 8'd2;

    localparam int SETUP_BYTES = 9;
    localparam int PIX_W       = 18;

    typedef struct packed {
        logic load_pix;
        logic set_fin;
        logic take_req;
        logic base;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic calc_busy;
        logic is_load;
        logic req_serve;
        logic req_over;
        logic can_issue;
        logic last_issue;
    } t_sts;

endpackage

// ===== src/bbrs_ram.sv =====
// ----------------------------------------------------------------------------
// bbrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbrs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bbrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbrs_ctrl
// Sequencer: takes items, starts packets and paces byte issue.
// ----------------------------------------------------------------------------
module bbrs_ctrl import bbrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tvalid,
    output logic o_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BASE = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_tready = (r_state == S_IDLE) && !i_sts.calc_busy;
    assign accept   = o_tready && i_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_pix = i_sts.is_load;
                    o_cmd.set_fin  = i_sts.req_over;
                    o_cmd.take_req = i_sts.req_serve;
                    if (i_sts.req_serve) begin
                        n_state = S_BASE;
                    end
                end
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_SEND;
            end
            S_SEND: begin
                if (i_sts.can_issue) begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.last_issue) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/bbrs_dpath.sv =====
// ----------------------------------------------------------------------------
// bbrs_dpath
// Config registers, block count, pixel bitmap, byte builder, output buffer.
// ----------------------------------------------------------------------------
module bbrs_dpath import bbrs_pkg::*; #(
    parameter int BLOCK_BYTES = 62,
    parameter int MAX_PIXELS  = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_tdata,
    input  logic                  i_op,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [7:0]            o_tdata,
    output logic                  o_tuser,
    output logic                  o_tlast
);

    localparam int PER_BLOCK = BLOCK_BYTES * 8;
    localparam int WORDS     = (MAX_PIXELS + 7) / 8;
    localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WORD_W    = 16 + $clog2(BLOCK_BYTES + 1);
    localparam int CMP_W     = WORD_W + 3;
    localparam int IDX_MAX   = (BLOCK_BYTES + 1 > SETUP_BYTES - 1) ?
                               BLOCK_BYTES + 1 : SETUP_BYTES - 1;
    localparam int IDX_W     = $clog2(IDX_MAX + 1);
    localparam int CALC_W    = PIX_W + 1;
    localparam int SHIFT     = CALC_W + $clog2(PER_BLOCK);
    localparam int RECIP_W   = CALC_W + 2;
    localparam int PROD_W    = CALC_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(PER_BLOCK) - 1) / longint'(PER_BLOCK);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    // input fields
    logic [15:0] pix_idx;
    logic [7:0]  pix_val;
    logic [7:0]  src_addr;
    logic [7:0]  pkt_len;
    logic [15:0] req_blk;

    assign pix_idx  = i_tdata[PIX_LSB +: 16];
    assign pix_val  = i_tdata[VAL_LSB +: 8];
    assign src_addr = i_tdata[SRC_LSB +: 8];
    assign pkt_len  = i_tdata[LEN_LSB +: 8];
    assign req_blk  = i_tdata[REQ_LSB +: 16];

    // configuration and block count
    logic [7:0]        r_src;
    logic [8:0]        r_width;
    logic [8:0]        r_height;
    logic [2:0]        r_calc;
    logic [PIX_W-1:0]  r_pixels;
    logic [PROD_W-1:0] r_prod;
    logic [15:0]       r_total;
    logic              size_we;
    logic [CALC_W-1:0] calc_x;
    logic [PROD_W-1:0] quot;

    assign size_we = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);
    assign calc_x  = CALC_W'(r_pixels) + CALC_W'(PER_BLOCK - 1);
    assign quot    = r_prod >> SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src    <= 8'd1;
            r_width  <= 9'd1;
            r_height <= 9'd1;
            r_calc   <= '0;
            r_pixels <= PIX_W'(1);
            r_total  <= 16'd1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SRC:    r_src    <= i_cfg_data[7:0];
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_calc <= {r_calc[1:0], size_we};
            if (r_calc[0]) begin
                r_pixels <= r_width * r_height;
            end
            if (r_calc[2]) begin
                r_total <= quot[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_calc[1]) begin
            r_prod <= calc_x * RECIP_V;
        end
    end

    // request decode
    logic r_fin;
    logic req_match;

    assign req_match = (i_op == OP_REQ) && (src_addr == r_src) && (pkt_len == REQ_LEN)
                       && !r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
        end else if (i_cmd.set_fin) begin
            r_fin <= 1'b1;
        end
    end

    // packet sequencing
    logic [15:0]       r_cb;
    logic              r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_word;
    logic [15:0]       cb_m1;
    logic              ram_byte;
    logic              last;
    logic [7:0]        hdr;
    logic [7:0]        setup_bytes [SETUP_BYTES];

    assign cb_m1    = r_cb - 16'd1;
    assign ram_byte = (r_kind == KIND_DATA) && (r_idx >= IDX_W'(2));
    assign last     = (r_kind == KIND_DATA) ? (r_idx == IDX_W'(BLOCK_BYTES + 1))
                                            : (r_idx == IDX_W'(SETUP_BYTES - 1));

    assign setup_bytes[0] = r_cb[15:8];
    assign setup_bytes[1] = r_cb[7:0];
    assign setup_bytes[2] = {7'd0, r_width[8]};
    assign setup_bytes[3] = r_width[7:0];
    assign setup_bytes[4] = {7'd0, r_height[8]};
    assign setup_bytes[5] = r_height[7:0];
    assign setup_bytes[6] = r_total[15:8];
    assign setup_bytes[7] = r_total[7:0];
    assign setup_bytes[8] = 8'(BLOCK_BYTES);

    always_comb begin
        if (r_kind == KIND_DATA) begin
            hdr = (r_idx == '0) ? r_cb[15:8] : r_cb[7:0];
        end else if (r_idx < IDX_W'(SETUP_BYTES)) begin
            hdr = setup_bytes[r_idx[3:0]];
        end else begin
            hdr = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_cb   <= req_blk;
            r_kind <= (req_blk != 16'd0) ? KIND_DATA : KIND_SETUP;
            r_idx  <= '0;
        end
        if (i_cmd.base) begin
            r_word <= WORD_W'(cb_m1 * BLOCK_BYTES);
        end
        if (i_cmd.issue) begin
            r_idx <= r_idx + IDX_W'(1);
            if (ram_byte) begin
                r_word <= r_word + WORD_W'(1);
            end
        end
    end

    // pixel mask for the byte at r_word
    logic [CMP_W-1:0] pos0;
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] avail;
    logic [7:0]       mask;

    assign pos0  = {r_word, 3'b000};
    assign lim   = (CMP_W'(r_pixels) > CMP_W'(MAX_PIXELS)) ? CMP_W'(MAX_PIXELS)
                                                          : CMP_W'(r_pixels);
    assign avail = lim - pos0;

    always_comb begin
        if (pos0 >= lim) begin
            mask = 8'h00;
        end else if (avail >= CMP_W'(8)) begin
            mask = 8'hff;
        end else begin
            mask = 8'hff >> (4'd8 - avail[3:0]);
        end
    end

    // bitmap: eight banks, bank = pixel index mod 8
    logic          load_we;
    logic [AW-1:0] waddr;
    logic [7:0]    ram_q;

    assign load_we = i_cmd.load_pix && ({1'b0, pix_idx} < 17'(MAX_PIXELS));
    assign waddr   = AW'(pix_idx[15:3]);

    for (genvar b = 0; b < 8; b++) begin : g_bank
        bbrs_ram #(
            .WIDTH (1),
            .DEPTH (WORDS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (load_we && (pix_idx[2:0] == 3'(b))),
            .i_waddr (waddr),
            .i_wdata (pix_val != WHITE_VALUE),
            .i_re    (i_cmd.issue && ram_byte),
            .i_raddr (r_word[AW-1:0]),
            .o_rdata (ram_q[b])
        );
    end

    // second stage, lines up with RAM read data
    logic       r_s2_valid;
    logic       r_s2_ram;
    logic [7:0] r_s2_hdr;
    logic [7:0] r_s2_mask;
    logic       r_s2_kind;
    logic       r_s2_last;
    logic [9:0] push_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s2_ram  <= ram_byte;
            r_s2_hdr  <= hdr;
            r_s2_mask <= mask;
            r_s2_kind <= r_kind;
            r_s2_last <= last;
        end
    end

    assign push_word = {r_s2_last, r_s2_kind, r_s2_ram ? (ram_q & r_s2_mask) : r_s2_hdr};

    // two-entry output buffer
    logic [9:0] r_fifo [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;
    logic [2:0] occ;

    assign pop = o_tvalid && i_tready;
    assign occ = {1'b0, r_count} + {2'd0, r_s2_valid} - {2'd0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= occ[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wptr] <= push_word;
        end
    end

    assign o_tvalid = (r_count != 2'd0);
    assign o_tdata  = r_fifo[r_rptr][7:0];
    assign o_tuser  = r_fifo[r_rptr][8];
    assign o_tlast  = r_fifo[r_rptr][9];

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.calc_busy  = size_we || (r_calc != 3'd0);
        o_sts.is_load    = (i_op == OP_LOAD);
        o_sts.req_serve  = req_match && (req_blk <= r_total);
        o_sts.req_over   = req_match && (req_blk > r_total);
        o_sts.can_issue  = (occ < 3'd2);
        o_sts.last_issue = last;
    end

endmodule

// ===== src/bitmap_block_request_server_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_request_server_top
// Pixel bitmap store that answers setup and data block requests bytewise.
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: index, value, source, length,
//                                           block; tuser: operation
// m_axis    out  m_axis_tvalid/tready       tdata: byte; tuser: kind; tlast
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// A pixel load leaves input ready. A served request passes S_BASE, then issues
// N = 9 (setup) or BLOCK_BYTES + 2 (data) bytes, then takes the next item,
// one byte per cycle while the buffer has room, from 8 banks read in parallel.
// A width or height write holds off input until the block count pipe is done.
// Output stalls back up through a two-entry buffer into byte issue.
// Reset clears control state only; the bitmap needs no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_block_request_server_top import bbrs_pkg::*; #(
    parameter int BLOCK_BYTES = 62,
    parameter int MAX_PIXELS  = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] pixel_index, [23:16] pixel_value, [31:24] source_address,
    // [39:32] packet_length, [55:40] block_number
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]            m_axis_tdata,
    // [0] packet_kind
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    bbrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    bbrs_dpath #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_PIXELS  (MAX_PIXELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (s_axis_tdata),
        .i_op        (s_axis_tuser[0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser[0]),
        .o_tlast     (m_axis_tlast)
    );

    a_issue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> sts.can_issue)
        else $error("byte issued without output buffer space");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !cmd.issue)
        else $error("byte issued while taking input");

    a_base_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take_req |=> cmd.base)
        else $error("block base not computed after request");

    a_calc_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT))
        |=> !s_axis_tready)
        else $error("input taken while block count is stale");

endmodule
